>>> rtl/sps_pkg.sv
// Shared types and constants of the stratified Poisson sampler.
`timescale 1ns / 1ps
package sps_pkg;

   localparam int PROB_W = 33;   // Q1.32 probability width
   localparam int MEAN_W = 32;   // Q8.24 mean width
   localparam int UNIF_W = 32;   // Q0.32 uniform width
   localparam int LCNT_W = 8;    // lower count / event count width
   localparam int THR_W  = 32;   // Q0.32 threshold width
   localparam int DIV_STEPS = PROB_W;
   localparam int STEP_W = $clog2(DIV_STEPS + 1);
   localparam int PP_W = 17 + MEAN_W;
   localparam logic [THR_W-1:0] THR_RESET = 32'd4295;
   localparam logic [PROB_W-1:0] PROB_MAX = {PROB_W{1'b1}};

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic term_max;
      logic sdiv_init;
      logic div_step;
      logic start_take;
      logic mul_hi;
      logic mul_lo;
      logic ldiv_init;
      logic loop_take;
      logic count_inc;
      logic set_cap;
      logic emit;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic small_mean;
      logic start_ovf;
      logic div_done;
      logic cont;
      logic at_cap;
      logic out_free;
   } status_type;

endpackage

>>> rtl/sps_ctrl.sv
// Sequencer of the sampler: unless the mean is small, start division (or saturation), then multiply/divide iterations.
`timescale 1ns / 1ps
module sps_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  sps_pkg::status_type stat,
   output sps_pkg::ctrl_type  cmd
);
   import sps_pkg::*;

   typedef enum logic [3:0] {
      IDLE, PRE, SDIV, CHECK, MUL_A, MUL_B, MSUM, LDIV, UPDATE, EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rdy_ff, rdy_in;

   assign req_tready = rdy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid && rdy_ff) begin
               cmd.load = 1'b1;
               state_in = PRE;
            end
         end
         PRE: begin
            if (stat.small_mean) begin
               state_in = EMIT;
            end else if (stat.start_ovf) begin
               cmd.term_max = 1'b1;
               state_in     = CHECK;
            end else begin
               cmd.sdiv_init = 1'b1;
               state_in      = SDIV;
            end
         end
         SDIV: begin
            if (stat.div_done) begin
               cmd.start_take = 1'b1;
               state_in       = CHECK;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         CHECK: begin
            if (!stat.cont) begin
               state_in = EMIT;
            end else if (stat.at_cap) begin
               cmd.set_cap = 1'b1;
               state_in    = EMIT;
            end else begin
               cmd.count_inc = 1'b1;
               state_in      = MUL_A;
            end
         end
         MUL_A: begin
            cmd.mul_hi = 1'b1;
            state_in   = MUL_B;
         end
         MUL_B: begin
            cmd.mul_lo = 1'b1;
            state_in   = MSUM;
         end
         MSUM: begin
            cmd.ldiv_init = 1'b1;
            state_in      = LDIV;
         end
         LDIV: begin
            if (stat.div_done) begin
               state_in = UPDATE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         UPDATE: begin
            cmd.loop_take = 1'b1;
            state_in      = CHECK;
         end
         EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
      rdy_in = (state_in == IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rdy_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         rdy_ff   <= rdy_in;
      end
   end

endmodule

>>> rtl/sps_dpath.sv
// Datapath of the sampler: operands, shared multiplier and divider, output word.
`timescale 1ns / 1ps
module sps_dpath #(
   parameter int MAX_COUNT = 255
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [sps_pkg::MEAN_W-1:0]   mean_rate,
   input  logic [sps_pkg::UNIF_W-1:0]   uniform_draw,
   input  logic [sps_pkg::LCNT_W-1:0]   lower_count,
   input  logic [sps_pkg::PROB_W-1:0]   proba_at_lower,
   input  logic [sps_pkg::PROB_W-1:0]   proba_in_stratum,
   input  logic                         csr_we,
   input  logic [sps_pkg::THR_W-1:0]    csr_wdata,
   input  sps_pkg::ctrl_type            cmd,
   output sps_pkg::status_type          stat,
   input  logic                         rsp_tready,
   output logic                         rsp_tvalid,
   output logic [sps_pkg::LCNT_W-1:0]   event_count,
   output logic                         capped
);
   import sps_pkg::*;

   localparam int CW_RAW = $clog2(MAX_COUNT + 1);
   localparam int CNT_W = (CW_RAW > LCNT_W) ? CW_RAW : LCNT_W;

   logic [THR_W-1:0]  thr_ff;
   logic [MEAN_W-1:0] mean_ff;
   logic [UNIF_W-1:0] unif_ff;
   logic [PROB_W-1:0] plow_ff, pstr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              cap_ff;
   logic [PROB_W-1:0] term_ff, sum_ff;
   logic [PP_W-1:0]   pphi_ff, pplo_ff;
   logic [PROB_W-1:0] rem_ff, dvd_ff, dsr_ff;
   logic [STEP_W-1:0] step_ff;
   logic              ovalid_ff;
   logic [LCNT_W-1:0] oevt_ff;
   logic              ocap_ff;

   logic [PROB_W:0]   trial, limit, ssum;
   logic              ge;
   logic [16:0]       mul_a;
   logic [PP_W-1:0]   mul_p;
   logic [64:0]       full;
   logic [40:0]       shifted;
   logic [PROB_W-1:0] mprod, new_sum;

   // Restoring division step: the quotient shifts into the dividend register.
   assign trial = {rem_ff, dvd_ff[PROB_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};

   assign mul_a = cmd.mul_hi ? term_ff[PROB_W-1:16] : {1'b0, term_ff[15:0]};
   assign mul_p = mul_a * mean_ff;

   assign full    = {pphi_ff, 16'd0} + {16'd0, pplo_ff};
   assign shifted = full[64:24];
   assign mprod   = (shifted[40:PROB_W] != '0) ? PROB_MAX : shifted[PROB_W-1:0];

   assign ssum    = {1'b0, sum_ff} + {1'b0, dvd_ff};
   assign new_sum = ssum[PROB_W] ? PROB_MAX : ssum[PROB_W-1:0];

   assign limit = {1'b0, 33'h1_0000_0000} - {2'b0, thr_ff};

   always_comb begin
      stat.small_mean = {mean_ff, 8'd0} < {8'd0, thr_ff};
      stat.start_ovf  = (pstr_ff == '0) || ({1'b0, plow_ff} >= {pstr_ff, 1'b0});
      stat.div_done   = (step_ff == '0);
      stat.cont       = ({1'b0, unif_ff} > sum_ff) && ({1'b0, sum_ff} < limit);
      stat.at_cap     = cnt_ff >= CNT_W'(MAX_COUNT);
      stat.out_free   = !ovalid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THR_RESET;
         ovalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         if (cmd.emit) begin
            ovalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mean_ff <= mean_rate;
         unif_ff <= uniform_draw;
         plow_ff <= proba_at_lower;
         pstr_ff <= proba_in_stratum;
         cnt_ff  <= CNT_W'(lower_count);
         cap_ff  <= 1'b0;
      end
      if (cmd.count_inc) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.set_cap) begin
         cap_ff <= 1'b1;
      end
      if (cmd.term_max) begin
         term_ff <= PROB_MAX;
         sum_ff  <= PROB_MAX;
      end
      if (cmd.start_take) begin
         term_ff <= dvd_ff;
         sum_ff  <= dvd_ff;
      end
      if (cmd.loop_take) begin
         term_ff <= dvd_ff;
         sum_ff  <= new_sum;
      end
      if (cmd.mul_hi) begin
         pphi_ff <= mul_p;
      end
      if (cmd.mul_lo) begin
         pplo_ff <= mul_p;
      end
      // The start term divides plow * 2^32; plow < 2 * pstr keeps it in 33 bits.
      if (cmd.sdiv_init) begin
         rem_ff  <= {1'b0, plow_ff[PROB_W-1:1]};
         dvd_ff  <= {plow_ff[0], 32'd0};
         dsr_ff  <= pstr_ff;
         step_ff <= STEP_W'(DIV_STEPS);
      end
      if (cmd.ldiv_init) begin
         rem_ff  <= '0;
         dvd_ff  <= mprod;
         dsr_ff  <= PROB_W'(cnt_ff);
         step_ff <= STEP_W'(DIV_STEPS);
      end
      if (cmd.div_step) begin
         rem_ff  <= ge ? PROB_W'(trial - {1'b0, dsr_ff}) : trial[PROB_W-1:0];
         dvd_ff  <= {dvd_ff[PROB_W-2:0], ge};
         step_ff <= step_ff - 1'b1;
      end
      if (cmd.emit) begin
         oevt_ff <= cnt_ff[LCNT_W-1:0];
         ocap_ff <= cap_ff;
      end
   end

   assign rsp_tvalid  = ovalid_ff;
   assign event_count = oevt_ff;
   assign capped      = ocap_ff;

endmodule

>>> rtl/stratified_poisson_sampler_unit.sv
// Top level of the stratified Poisson sampler.
//
// One word on req_ (stream slave) carries mean, uniform draw, lower count and
// the two stratum probabilities; one word on rsp_ (stream master) returns the
// sampled count in tdata and the cap flag in tuser. The threshold register is
// written through csr_valid/csr_wdata, which is always ready.
// The block works on one word at a time. A small mean goes straight to the
// output. Otherwise the start term takes a 33-step restoring division, or is
// saturated when it would not fit in 33 bits, and each further count costs a
// high and a low pass on a 17x32 multiplier, a sum step, 33 steps of the same
// shared divider and one update, bounded by the MAX_COUNT iteration cap.
// A finished word sits in an output register; req_tready returns as soon as
// it is loaded there, so the next word can be taken while it waits. If the
// receiver stalls with a word still pending, the next result waits in its
// final state until the register frees.
// Synchronous reset empties the output, returns to idle and sets the
// threshold to its reset value.
`timescale 1ns / 1ps
module stratified_poisson_sampler_unit #(
   parameter int MAX_COUNT = 255
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mean_rate[31:0], uniform_draw[63:32], lower_count[71:64],
   // proba_at_lower[104:72], proba_in_stratum[137:105], zeros above
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // event_count[7:0]
   output logic [7:0]   rsp_tdata,
   // capped[0]
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_wdata
);
   import sps_pkg::*;

   ctrl_type   cmd;
   status_type stat;

   assign csr_ready = 1'b1;

   sps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sps_dpath #(
      .MAX_COUNT (MAX_COUNT)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .mean_rate        (req_tdata[31:0]),
      .uniform_draw     (req_tdata[63:32]),
      .lower_count      (req_tdata[71:64]),
      .proba_at_lower   (req_tdata[104:72]),
      .proba_in_stratum (req_tdata[137:105]),
      .csr_we           (csr_valid),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .event_count      (rsp_tdata),
      .capped           (rsp_tuser)
   );

endmodule
